// ===== hw/rtl/mbms_pkg.sv =====
// ----------------------------------------------------------------------------
// Mean-square dB meter package
// Shared constants for the block mean-square level meter.
// ----------------------------------------------------------------------------
package mbms_pkg;

    localparam int DEF_MAX_BLOCK   = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 16;
    localparam int COUNT_W   = 13;
    localparam int MUL_W     = 32;
    localparam int MANT_BITS = 31;
    localparam int FRAC_BITS = 16;
    localparam int ROUND_W   = 4;

    // 10*log10(2) in Q.24.
    localparam logic [MUL_W-1:0] DB_PER_LOG2_Q24 = 32'd50504453;

    localparam logic [LEVEL_W-1:0] LEVEL_LOWEST = 16'h8000;
    localparam logic [LEVEL_W-1:0] LEVEL_SAT    = 16'h8000;

endpackage

// ===== hw/rtl/mbms_mul.sv =====
// ----------------------------------------------------------------------------
// Mean-square dB meter shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mbms_mul (
    input  logic                          clk,
    input  logic [mbms_pkg::MUL_W-1:0]    a,
    input  logic [mbms_pkg::MUL_W-1:0]    b,
    output logic [2*mbms_pkg::MUL_W-1:0]  prod
);

    logic [2*mbms_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/mbms_norm.sv =====
// ----------------------------------------------------------------------------
// Mean-square dB meter normaliser
// Finds the top set bit of a non-zero word by shifting one place a cycle.
// ----------------------------------------------------------------------------
module mbms_norm #(
    parameter int NW = 63,
    parameter int PW = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [NW-1:0]                    value,
    output logic                             done,
    output logic [PW-1:0]                    msb_index,
    output logic [mbms_pkg::MANT_BITS-1:0]   mant
);

    logic          busy_reg;
    logic [NW-1:0] val_reg;
    logic [PW-1:0] idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            val_reg  <= '0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            val_reg  <= value;
            idx_reg  <= PW'(NW - 1);
        end
        else if (busy_reg)
        begin
            if (val_reg[NW-1])
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                val_reg <= {val_reg[NW-2:0], 1'b0};
                idx_reg <= idx_reg - PW'(1);
            end
        end
    end

    assign done      = busy_reg && val_reg[NW-1];
    assign msb_index = idx_reg;
    assign mant      = val_reg[NW-1 -: mbms_pkg::MANT_BITS];

endmodule

// ===== hw/rtl/block_mean_square_db_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Block mean-square dB meter
// Accumulates squared samples per block and reports the mean-square level.
// ----------------------------------------------------------------------------
// Each sample transfer passes through the transfer itself, a square on the
// shared multiplier and the accumulate, and no new sample is taken until the
// accumulate is done. At the end of a block the meter takes two base-two
// logarithms on the same multiplier, each needing a start state, one-bit
// normalising over up to NW bits (NW is the accumulator width, 43 bits by
// default) and one squaring round per fraction bit, followed by scaling to dB
// and a load of the result register; a silent block skips all of this. The
// result waits in its own register, so a new block may start while the
// previous result is still being taken.
module block_mean_square_db_meter_unit #(
    parameter int MAX_BLOCK   = mbms_pkg::DEF_MAX_BLOCK,
    parameter int SAMPLE_BITS = mbms_pkg::DEF_SAMPLE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] level_db, [28:16] block_samples
    output logic [1:0]  m_axis_tuser    // [0] silent, [1] forced_end
);

    localparam int SW  = (SAMPLE_BITS > mbms_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                            : mbms_pkg::SAMPLE_W;
    localparam int EW  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_BLOCK);
    localparam int CW  = $clog2(MAX_BLOCK + 1);
    localparam int NW0 = (EW > CW) ? EW : CW;
    localparam int NW  = (NW0 > mbms_pkg::MANT_BITS) ? NW0 : mbms_pkg::MANT_BITS;
    localparam int PW  = $clog2(NW);
    localparam int LW  = PW + mbms_pkg::FRAC_BITS;
    localparam int AW  = LW + 1;
    localparam int MW  = mbms_pkg::MUL_W;
    localparam int MB  = mbms_pkg::MANT_BITS;
    localparam int FB  = mbms_pkg::FRAC_BITS;
    localparam logic [AW-1:0] FS_OFFSET = AW'((2 * (SAMPLE_BITS - 1)) * (2 ** FB));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACC,
        ST_NORM_GO,
        ST_NORM_WAIT,
        ST_RND_MUL,
        ST_RND_FIX,
        ST_SCALE_MUL,
        ST_SCALE_FIX,
        ST_OUT
    } state_t;

    state_t                                  state_reg;
    logic [SAMPLE_BITS-1:0]                  mag_reg;
    logic                                    last_reg;
    logic [EW-1:0]                           sum_reg;
    logic [CW-1:0]                           cnt_reg;
    logic                                    forced_reg;
    logic                                    silent_reg;
    logic                                    which_reg;
    logic [MB-1:0]                           m_reg;
    logic [PW-1:0]                           p_reg;
    logic [FB-1:0]                           frac_reg;
    logic [mbms_pkg::ROUND_W-1:0]            rnd_reg;
    logic [AW-1:0]                           a_reg;
    logic [MW-1:0]                           att_reg;
    logic [mbms_pkg::LEVEL_W-1:0]            level_reg;
    logic                                    out_valid_reg;
    logic [mbms_pkg::LEVEL_W-1:0]            out_level_reg;
    logic [mbms_pkg::COUNT_W-1:0]            out_samples_reg;
    logic                                    out_silent_reg;
    logic                                    out_forced_reg;

    logic [SW-1:0]                           ext;
    logic [SAMPLE_BITS-1:0]                  v;
    logic [SAMPLE_BITS-1:0]                  mag;
    logic [MW-1:0]                           mul_a;
    logic [MW-1:0]                           mul_b;
    logic [2*MW-1:0]                         prod;
    logic [EW-1:0]                           sum_next;
    logic [CW-1:0]                           cnt_next;
    logic                                    block_end;
    logic                                    norm_start;
    logic [NW-1:0]                           norm_value;
    logic                                    norm_done;
    logic [PW-1:0]                           norm_p;
    logic [MB-1:0]                           norm_mant;
    logic [MW-1:0]                           sq;
    logic [MB-1:0]                           m_new;
    logic [FB-1:0]                           frac_new;
    logic [AW-1:0]                           log_val;
    logic [MW-1:0]                           att;
    logic [2*MW-1:0]                         rnd_sum;
    logic [MW-1:0]                           q;
    logic [mbms_pkg::LEVEL_W-1:0]            q_sat;

    mbms_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mbms_norm #(
        .NW (NW),
        .PW (PW)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (norm_start),
        .value     (norm_value),
        .done      (norm_done),
        .msb_index (norm_p),
        .mant      (norm_mant)
    );

    always_comb
    begin
        ext = SW'(s_axis_tdata);
        v   = ext[SAMPLE_BITS-1:0];
        mag = v[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - v) : v;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_SQUARE:
            begin
                mul_a = MW'(mag_reg);
                mul_b = MW'(mag_reg);
            end
            ST_RND_MUL:
            begin
                mul_a = MW'(m_reg);
                mul_b = MW'(m_reg);
            end
            ST_SCALE_MUL:
            begin
                mul_a = att_reg;
                mul_b = mbms_pkg::DB_PER_LOG2_Q24;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        sum_next   = sum_reg + EW'(prod);
        cnt_next   = cnt_reg + CW'(1);
        block_end  = last_reg || (cnt_next == CW'(MAX_BLOCK));
        norm_start = (state_reg == ST_NORM_GO);
        norm_value = which_reg ? NW'(sum_reg) : NW'(cnt_reg);
        sq         = prod[MB+MB-1:MB-1];
        m_new      = sq[MB] ? sq[MB:1] : sq[MB-1:0];
        frac_new   = {frac_reg[FB-2:0], sq[MB]};
        log_val    = AW'({p_reg, frac_new});
        att        = (a_reg > log_val) ? MW'(a_reg - log_val) : '0;
        rnd_sum    = prod + (2*MW)'(64'h8000_0000);
        q          = rnd_sum[2*MW-1:MW];
        q_sat      = (q > MW'(32768)) ? mbms_pkg::LEVEL_SAT : q[mbms_pkg::LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mag_reg         <= '0;
            last_reg        <= 1'b0;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            forced_reg      <= 1'b0;
            silent_reg      <= 1'b0;
            which_reg       <= 1'b0;
            m_reg           <= '0;
            p_reg           <= '0;
            frac_reg        <= '0;
            rnd_reg         <= '0;
            a_reg           <= '0;
            att_reg         <= '0;
            level_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_level_reg   <= '0;
            out_samples_reg <= '0;
            out_silent_reg  <= 1'b0;
            out_forced_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        mag_reg   <= mag;
                        last_reg  <= s_axis_tlast;
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                    if (!block_end)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        forced_reg <= !last_reg;
                        which_reg  <= 1'b0;
                        if (sum_next == '0)
                        begin
                            silent_reg <= 1'b1;
                            level_reg  <= mbms_pkg::LEVEL_LOWEST;
                            state_reg  <= ST_OUT;
                        end
                        else
                        begin
                            silent_reg <= 1'b0;
                            state_reg  <= ST_NORM_GO;
                        end
                    end
                end
                ST_NORM_GO:
                begin
                    state_reg <= ST_NORM_WAIT;
                end
                ST_NORM_WAIT:
                begin
                    if (norm_done)
                    begin
                        m_reg     <= norm_mant;
                        p_reg     <= norm_p;
                        frac_reg  <= '0;
                        rnd_reg   <= mbms_pkg::ROUND_W'(FB - 1);
                        state_reg <= ST_RND_MUL;
                    end
                end
                ST_RND_MUL:
                begin
                    state_reg <= ST_RND_FIX;
                end
                ST_RND_FIX:
                begin
                    m_reg    <= m_new;
                    frac_reg <= frac_new;
                    rnd_reg  <= rnd_reg - mbms_pkg::ROUND_W'(1);
                    if (rnd_reg != '0)
                    begin
                        state_reg <= ST_RND_MUL;
                    end
                    else if (!which_reg)
                    begin
                        a_reg     <= log_val + FS_OFFSET;
                        which_reg <= 1'b1;
                        state_reg <= ST_NORM_GO;
                    end
                    else
                    begin
                        att_reg   <= att;
                        state_reg <= ST_SCALE_MUL;
                    end
                end
                ST_SCALE_MUL:
                begin
                    state_reg <= ST_SCALE_FIX;
                end
                ST_SCALE_FIX:
                begin
                    level_reg <= mbms_pkg::LEVEL_W'(0) - q_sat;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_level_reg   <= level_reg;
                        out_samples_reg <= mbms_pkg::COUNT_W'(cnt_reg);
                        out_silent_reg  <= silent_reg;
                        out_forced_reg  <= forced_reg;
                        sum_reg         <= '0;
                        cnt_reg         <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_samples_reg, out_level_reg};
    assign m_axis_tuser  = {out_forced_reg, out_silent_reg};

endmodule

// ===== sim/tb_block_mean_square_db_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Testbench for the block mean-square dB meter
// Streams signed samples in blocks of random length and content into the
// meter, with random idle cycles on both the sample and the result stream.
// A bit-exact predictor of the block energy and its fixed-point logarithm
// works out the level report expected for each closed block, and every
// report transfer is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_block_mean_square_db_meter_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN      = mbms_pkg::DEF_MAX_BLOCK;
    localparam int SBITS        = mbms_pkg::DEF_SAMPLE_BITS;
    localparam int RANDOM_ITEMS = 1680;
    localparam int TAIL_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [mbms_pkg::SAMPLE_W-1:0] sample;
        logic                          last;
        logic                          wait_drain;
    } sample_xfer_t;

    typedef struct packed {
        logic [mbms_pkg::LEVEL_W-1:0] level_db;
        logic                         silent;
        logic                         forced_end;
        logic [mbms_pkg::COUNT_W-1:0] block_samples;
    } level_report_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    sample_xfer_t  pending_samples[$];
    level_report_t expected_levels[$];

    logic [63:0] energy_acc = '0;
    int unsigned block_len = 0;
    int unsigned levels_predicted = 0;
    int unsigned levels_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;

    block_mean_square_db_meter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (cycle_count[11:10] == 2'b11 || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int unsigned top;
        logic [63:0] mant;
        logic [mbms_pkg::FRAC_BITS-1:0] frac;
        top = 0;
        frac = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                top = i;
            end
        end
        if (top >= 30)
        begin
            mant = x >> (top - 30);
        end
        else
        begin
            mant = x << (30 - top);
        end
        for (int i = mbms_pkg::FRAC_BITS - 1; i >= 0; i--)
        begin
            mant = (mant * mant) >> 30;
            if (mant >= 64'h8000_0000)
            begin
                mant = mant >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(top) << mbms_pkg::FRAC_BITS) | 64'(frac);
    endfunction

    task automatic accumulate_sample(input logic [mbms_pkg::SAMPLE_W-1:0] sample,
                                     input logic last);
        logic [16:0]   mag;
        logic          forced;
        logic [63:0]   count_log;
        logic [63:0]   energy_log;
        logic [63:0]   atten;
        logic [63:0]   db_mag;
        logic [63:0]   level_full;
        level_report_t rep;
        if (sample[mbms_pkg::SAMPLE_W-1])
        begin
            mag = 17'h10000 - {1'b0, sample};
        end
        else
        begin
            mag = {1'b0, sample};
        end
        energy_acc = energy_acc + 64'(mag) * 64'(mag);
        block_len++;
        forced = !last && block_len >= MAX_LEN;
        if (last || forced)
        begin
            if (energy_acc == 0)
            begin
                rep.level_db = mbms_pkg::LEVEL_LOWEST;
                rep.silent = 1'b1;
            end
            else
            begin
                count_log = log2_fixed(64'(block_len)) +
                            (64'(2 * (SBITS - 1)) << mbms_pkg::FRAC_BITS);
                energy_log = log2_fixed(energy_acc);
                atten = (count_log > energy_log) ? count_log - energy_log : 64'd0;
                db_mag = (atten * 64'(mbms_pkg::DB_PER_LOG2_Q24) + 64'h8000_0000) >> 32;
                if (db_mag > 64'd32768)
                begin
                    db_mag = 64'd32768;
                end
                level_full = 64'd65536 - db_mag;
                rep.level_db = level_full[mbms_pkg::LEVEL_W-1:0];
                rep.silent = 1'b0;
            end
            rep.forced_end = forced;
            rep.block_samples = block_len[mbms_pkg::COUNT_W-1:0];
            expected_levels.push_back(rep);
            levels_predicted++;
            energy_acc = '0;
            block_len = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input level_report_t want,
                                   input level_report_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $write("%0t: %s: expected level %0d silent %0b forced %0b count %0d, ",
                   $realtime, what, $signed(want.level_db), want.silent, want.forced_end,
                   want.block_samples);
            $display("got level %0d silent %0b forced %0b count %0d",
                     $signed(got.level_db), got.silent, got.forced_end, got.block_samples);
        end
    endtask

    task automatic queue_sample(input logic [mbms_pkg::SAMPLE_W-1:0] v, input logic last,
                                input logic drain);
        sample_xfer_t x;
        x.sample = v;
        x.last = last;
        x.wait_drain = drain;
        pending_samples.push_back(x);
    endtask

    function automatic logic [mbms_pkg::SAMPLE_W-1:0] pick_sample(input int unsigned kind);
        int unsigned r;
        logic [mbms_pkg::SAMPLE_W-1:0] v;
        case (kind)
            0: v = '0;
            1:
            begin
                r = $urandom_range(0, 2);
                v = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : 16'h8001;
            end
            2:
            begin
                r = $urandom_range(0, 6);
                v = mbms_pkg::SAMPLE_W'(r) - mbms_pkg::SAMPLE_W'(3);
            end
            3: v = ($urandom_range(0, 7) == 0) ? mbms_pkg::SAMPLE_W'($urandom()) : '0;
            default: v = mbms_pkg::SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    task automatic queue_block(input int unsigned len, input int unsigned kind,
                               input logic drain, input logic with_last);
        for (int unsigned i = 0; i < len; i++)
        begin
            queue_sample(pick_sample(kind), with_last && i == len - 1, drain && i == 0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sender
        sample_xfer_t nxt;
        logic free;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tlast <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            free = !s_axis_tvalid || s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                accumulate_sample(s_axis_tdata, s_axis_tlast);
            end
            if (free)
            begin
                if (send_gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_samples.size() != 0 &&
                         !(pending_samples[0].wait_drain && levels_checked != levels_predicted))
                begin
                    nxt = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt.sample;
                    s_axis_tlast <= nxt.last;
                    send_gap <= idle_len();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        level_report_t got;
        level_report_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.level_db = m_axis_tdata[15:0];
                got.silent = m_axis_tuser[0];
                got.forced_end = m_axis_tuser[1];
                got.block_samples = m_axis_tdata[28:16];
                if (expected_levels.size() == 0)
                begin
                    want = '0;
                    report_mismatch("report with none expected", want, got);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (got != want)
                    begin
                        report_mismatch("level report mismatch", want, got);
                    end
                end
                levels_checked <= levels_checked + 1;
            end
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left <= idle_len();
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned random_items;
        int unsigned r;
        int unsigned len;

        // Single-sample blocks at the extremes, silent blocks and bit patterns.
        queue_sample(16'h0000, 1'b1, 1'b0);
        queue_sample(16'h8000, 1'b1, 1'b0);
        queue_sample(16'h7FFF, 1'b1, 1'b0);
        queue_sample(16'h0001, 1'b1, 1'b0);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        queue_sample(16'h0000, 1'b0, 1'b0);
        queue_sample(16'h0000, 1'b0, 1'b0);
        queue_sample(16'h0000, 1'b1, 1'b0);
        queue_sample(16'h0000, 1'b0, 1'b0);
        queue_sample(16'h0001, 1'b1, 1'b0);
        queue_sample(16'h4000, 1'b0, 1'b0);
        queue_sample(16'hC000, 1'b0, 1'b0);
        queue_sample(16'h7FFF, 1'b0, 1'b0);
        queue_sample(16'h8000, 1'b1, 1'b0);
        queue_sample(16'h5555, 1'b0, 1'b0);
        queue_sample(16'hAAAA, 1'b1, 1'b0);
        queue_sample(16'h8000, 1'b0, 1'b0);
        queue_sample(16'h8000, 1'b1, 1'b0);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = $urandom_range(1, 8);
            end
            else if (r < 95)
            begin
                len = $urandom_range(9, 64);
            end
            else
            begin
                len = $urandom_range(65, 400);
            end
            queue_block(len, $urandom_range(0, 9), random_items == 0, 1'b1);
            random_items += len;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(negedge clk);
        end
        while (pending_samples.size() != 0 || s_axis_tvalid ||
               levels_checked != levels_predicted);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_levels.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
